// ===== rtl/rle_pkg.sv =====
// ----------------------------------------------------------------------------
// rle_pkg
// Shared types, constants and helpers of the run-length text encoder.
// ----------------------------------------------------------------------------
package rle_pkg;

    // Longest run before a split; clamped to the 16-bit run counter.
    localparam longint unsigned MAX_RUN = 65535;
    localparam logic [15:0] RUN_CAP =
        (MAX_RUN > 65535) ? 16'hFFFF : ((MAX_RUN < 1) ? 16'd1 : 16'(MAX_RUN));

    // Run queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Input command codes
    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_EOS  = 1'b1;

    // Decimal place indexes (ones place is index zero)
    localparam logic [2:0] PLACE_ONES = 3'd0;
    localparam logic [2:0] PLACE_TOP  = 3'd4;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;

    // One finished run waiting to be written out
    typedef struct packed {
        logic [15:0] length;
        logic [7:0]  value;
    } rle_run_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } rle_q_status_t;

    // Digit of one decimal place and the remainder below it
    typedef struct packed {
        logic [3:0]  digit;
        logic [15:0] rest;
    } rle_digit_t;

    function automatic logic [16:0] place_value(input logic [2:0] idx);
        logic [16:0] p;
        case (idx)
            3'd0:    p = 17'd1;
            3'd1:    p = 17'd10;
            3'd2:    p = 17'd100;
            3'd3:    p = 17'd1000;
            default: p = 17'd10000;
        endcase
        return p;
    endfunction

    // Index of the most significant nonzero place (zero for values below ten)
    function automatic logic [2:0] top_place(input logic [15:0] v);
        logic [2:0] idx;
        if (v >= 16'd10000)
            idx = 3'd4;
        else if (v >= 16'd1000)
            idx = 3'd3;
        else if (v >= 16'd100)
            idx = 3'd2;
        else if (v >= 16'd10)
            idx = 3'd1;
        else
            idx = 3'd0;
        return idx;
    endfunction

    // Digit at one place: parallel compares against the nine multiples
    function automatic rle_digit_t digit_at(input logic [15:0] rem, input logic [2:0] idx);
        rle_digit_t  r;
        logic [16:0] p;
        logic [20:0] m;
        logic [16:0] sub;
        p   = place_value(idx);
        r.digit = 4'd0;
        sub = 17'd0;
        for (int k = 1; k <= 9; k++)
        begin
            m = 21'(k) * 21'(p);
            if (21'(rem) >= m)
            begin
                r.digit = 4'(k);
                sub     = m[16:0];
            end
        end
        r.rest = 16'(17'(rem) - sub);
        return r;
    endfunction

endpackage

// ===== rtl/rle_text_encoder_core.sv =====
// ----------------------------------------------------------------------------
// rle_text_encoder_core
// Run-length text encoder: each run leaves as its length in ASCII decimal,
// no leading zeros, followed by the repeated byte.
//
//   Channel | Direction | tdata          | tuser/tlast
//   s_*     | in        | [7:0] data_byte | tuser: command (1 = end of stream)
//   m_*     | out       | [7:0] out_byte  | tlast: last word of a run's code
//
// The input takes one word per cycle while the four-entry run queue has room.
// A run of length L writes digits(L)+1 words at one word per cycle on the
// output register unless stalled; all-distinct bytes give two words each.
// The writer loads the next run in the cycle it writes the current run's byte.
// Reset clears run tracking, queue and output valid; no clearing pass.
// Output stalls fill the queue and then hold s_tready low.
// ----------------------------------------------------------------------------
module rle_text_encoder_core
    import rle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] command
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);

    rle_q_status_t q_status;
    rle_run_t      push_run;
    rle_run_t      head_run;
    logic          q_push;
    logic          q_pop;

    rle_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_cmd   (s_tuser),
        .in_byte  (s_tdata),
        .q_status (q_status),
        .q_push   (q_push),
        .q_run    (push_run)
    );

    rle_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_run (push_run),
        .pop      (q_pop),
        .head_run (head_run),
        .status   (q_status)
    );

    rle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_head    (head_run),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

// ===== rtl/rle_queue.sv =====
// ----------------------------------------------------------------------------
// rle_queue
// Short FIFO of finished runs between the classifying front and the writer.
// ----------------------------------------------------------------------------
module rle_queue
    import rle_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rle_run_t      push_run,
    input  logic          pop,
    output rle_run_t      head_run,
    output rle_q_status_t status
);

    rle_run_t           mem_reg [QDEPTH];
    logic [QAW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]       count_reg,  count_next;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_run;
    end

    assign head_run     = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == (QAW+1)'(QDEPTH));
    assign status.empty = (count_reg == '0);

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!status.full || pop))
        else $error("run queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("run queue read while empty");

endmodule

// ===== rtl/rle_front.sv =====
// ----------------------------------------------------------------------------
// rle_front
// Takes input words, tracks the pending run and queues runs as they close.
// ----------------------------------------------------------------------------
module rle_front
    import rle_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          in_cmd,
    input  logic [7:0]    in_byte,
    input  rle_q_status_t q_status,
    output logic          q_push,
    output rle_run_t      q_run
);

    logic [15:0] run_len_reg, run_len_next;
    logic [7:0]  run_val_reg, run_val_next;
    logic        accept;
    logic        pending;
    logic        extend;

    // A run is only closed into the queue, so stall while it has no room
    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign pending  = (run_len_reg != '0);
    assign extend   = pending && (in_byte == run_val_reg) && (run_len_reg < RUN_CAP);

    // Run tracking
    always_comb
    begin
        run_len_next = run_len_reg;
        run_val_next = run_val_reg;
        q_push       = 1'b0;
        if (accept)
        begin
            if (in_cmd == CMD_EOS)
            begin
                q_push       = pending;
                run_len_next = '0;
                run_val_next = '0;
            end
            else if (extend)
            begin
                run_len_next = run_len_reg + 1'b1;
            end
            else
            begin
                q_push       = pending;
                run_len_next = 16'd1;
                run_val_next = in_byte;
            end
        end
    end

    assign q_run.length = run_len_reg;
    assign q_run.value  = run_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_len_reg <= '0;
            run_val_reg <= '0;
        end
        else
        begin
            run_len_reg <= run_len_next;
            run_val_reg <= run_val_next;
        end
    end

    a_len_capped: assert property (@(posedge clk) disable iff (!rst_n)
        run_len_reg <= RUN_CAP)
        else $error("run length beyond cap");

    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (run_len_reg == '0) |-> (run_val_reg == '0))
        else $error("stale run byte with no run pending");

endmodule

// ===== rtl/rle_back.sv =====
// ----------------------------------------------------------------------------
// rle_back
// Writes each queued run as decimal digits, most significant first, then its
// byte, one word per cycle through a registered output unless it stalls.
// ----------------------------------------------------------------------------
module rle_back
    import rle_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  rle_q_status_t q_status,
    input  rle_run_t      q_head,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          out_last
);

    logic        act_reg,   act_next;
    logic        dig_reg,   dig_next;
    logic [2:0]  idx_reg,   idx_next;
    logic [15:0] rem_reg,   rem_next;
    logic [7:0]  val_reg,   val_next;
    logic        ovalid_reg, ovalid_next;
    logic [7:0]  obyte_reg,  obyte_next;
    logic        olast_reg,  olast_next;
    logic        slot_free;
    rle_digit_t  cur;

    assign slot_free = !ovalid_reg || out_ready;
    assign cur       = digit_at(rem_reg, idx_reg);
    assign q_pop     = !q_status.empty &&
                       (!act_reg || (!dig_reg && slot_free));

    // Writer sequencer
    always_comb
    begin
        act_next    = act_reg;
        dig_next    = dig_reg;
        idx_next    = idx_reg;
        rem_next    = rem_reg;
        val_next    = val_reg;
        ovalid_next = ovalid_reg;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;

        if (slot_free)
        begin
            ovalid_next = 1'b0;
            if (act_reg)
            begin
                ovalid_next = 1'b1;
                if (dig_reg)
                begin
                    obyte_next = ASCII_ZERO + 8'(cur.digit);
                    olast_next = 1'b0;
                    rem_next   = cur.rest;
                    if (idx_reg == PLACE_ONES)
                        dig_next = 1'b0;
                    else
                        idx_next = idx_reg - 1'b1;
                end
                else
                begin
                    obyte_next = val_reg;
                    olast_next = 1'b1;
                    act_next   = 1'b0;
                end
            end
        end

        // Load the next run when idle or while the current one writes its byte
        if (q_pop)
        begin
            act_next = 1'b1;
            dig_next = 1'b1;
            idx_next = top_place(q_head.length);
            rem_next = q_head.length;
            val_next = q_head.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            act_reg    <= act_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg   <= dig_next;
        idx_reg   <= idx_next;
        rem_reg   <= rem_next;
        val_reg   <= val_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

    assign out_valid = ovalid_reg;
    assign out_byte  = obyte_reg;
    assign out_last  = olast_reg;

    a_digit_ascii: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !olast_reg) |-> (obyte_reg >= ASCII_ZERO && obyte_reg <= ASCII_NINE))
        else $error("non-digit word before the run byte");

    a_place_range: assert property (@(posedge clk) disable iff (!rst_n)
        (act_reg && dig_reg) |-> (idx_reg <= PLACE_TOP))
        else $error("decimal place index out of range");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rle_text_encoder_core. Byte streams go in on the
// s_* port with random gaps. The bench keeps its own copy of the pending run
// and builds the expected code words (decimal run length, then the run's
// byte) as each word is accepted. Every word out of m_* is checked against
// that store, with random output stalls and one long hold-off.
// ----------------------------------------------------------------------------
module testbench
    import rle_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int          TAIL_CYCLES = 20;
    localparam int          RANDOM_ITEMS = 40;

    // One expected output word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } code_word_t;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] data_byte
    logic       s_tuser;   // [0] command
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] out_byte
    logic       m_tlast;

    // Mirror of the encoder state and the expected code words
    logic [15:0] run_len;
    logic [7:0]  run_byte;
    code_word_t  code_q[$];

    int          errors;
    int unsigned cycles;
    bit          tx_quiet;
    bit          rx_quiet;
    int          hold_cycles;

    rle_text_encoder_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 20);
    endfunction

    // Queue the digits of the pending run, most significant first, then its byte
    function automatic void flush_run();
        logic [7:0]  digs[5];
        int          nd;
        int unsigned v;
        nd = 0;
        v  = 32'(run_len);
        do
        begin
            digs[nd] = ASCII_ZERO + 8'(v % 10);
            nd++;
            v = v / 10;
        end
        while (v != 0);
        for (int i = nd - 1; i >= 0; i--)
            code_q.push_back('{out_byte: digs[i], last: 1'b0});
        code_q.push_back('{out_byte: run_byte, last: 1'b1});
    endfunction

    // Update the run mirror for one accepted word
    function automatic void encode_input(input logic cmd, input logic [7:0] data);
        if (cmd == CMD_EOS)
        begin
            if (run_len != 0)
                flush_run();
            run_len  = '0;
            run_byte = '0;
        end
        else if (run_len != 0 && data == run_byte && run_len < RUN_CAP)
        begin
            run_len = run_len + 16'd1;
        end
        else
        begin
            if (run_len != 0)
                flush_run();
            run_len  = 16'd1;
            run_byte = data;
        end
    endfunction

    // Offer one word and wait for it to be taken; valid stays up between
    // back-to-back words
    task automatic send_word(input logic cmd, input logic [7:0] data);
        int gap;
        gap = pick_gap(tx_quiet);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        encode_input(cmd, data);
    endtask

    task automatic send_run(input logic [7:0] data, input int len);
        for (int i = 0; i < len; i++)
            send_word(CMD_DATA, data);
    endtask

    // Drop valid and wait for every expected word to come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (code_q.size() != 0)
            @(posedge clk);
    endtask

    // Output side: random stalls, plus a long hold-off on request
    initial
    begin
        int stall;
        stall = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else if (!rx_quiet && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                stall = pick_gap(1'b0);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Check each output word against the oldest expected one
    always @(posedge clk)
    begin
        code_word_t exp_w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (code_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: tdata=%02h tlast=%b", m_tdata, m_tlast);
            end
            else
            begin
                exp_w = code_q.pop_front();
                if (m_tdata !== exp_w.out_byte || m_tlast !== exp_w.last)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: tdata exp %02h got %02h, tlast exp %b got %b",
                                 exp_w.out_byte, m_tdata, exp_w.last, m_tlast);
                end
            end
        end
    end

    // Field extremes, empty stream, zero first byte, end-of-stream reset
    task automatic test_directed();
        send_word(CMD_EOS, 8'hFF);          // nothing pending: no output
        send_word(CMD_DATA, 8'h00);         // zero byte still opens a run
        send_word(CMD_EOS, 8'h00);
        send_run(8'hFF, 3);
        send_word(CMD_DATA, 8'h00);
        send_word(CMD_DATA, 8'h55);
        send_word(CMD_DATA, 8'hAA);
        send_word(CMD_DATA, 8'h01);
        send_word(CMD_DATA, 8'h80);
        send_word(CMD_EOS, 8'hA5);          // data ignored on end of stream
        send_word(CMD_EOS, 8'h5A);          // back-to-back end of stream
        send_word(CMD_DATA, 8'h41);
        send_word(CMD_EOS, 8'h41);
        send_word(CMD_DATA, 8'h41);         // same byte, new stream
        send_run(8'h7E, 10);
        send_word(CMD_EOS, 8'h00);
        drain();
    endtask

    // Digit-count boundaries of the run length
    task automatic test_run_lengths();
        int lens[5];
        lens = '{1, 2, 9, 10, 11};
        tx_quiet = 1'b1;
        foreach (lens[i])
            send_run(8'(8'h30 + i), lens[i]);
        send_word(CMD_EOS, 8'h00);
        drain();
        tx_quiet = 1'b0;
    endtask

    // Random streams of runs with some stray end-of-stream words
    task automatic test_random();
        int         n;
        int         len;
        logic [7:0] b;
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                n++;
            end
            else
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30)
                                                  : $urandom_range(1, 12);
                b   = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(8'h41, 8'h43))
                                                  : 8'($urandom_range(0, 255));
                send_run(b, len);
                n += len;
                if ($urandom_range(0, 4) == 0)
                begin
                    send_word(CMD_EOS, 8'($urandom_range(0, 255)));
                    n++;
                end
            end
        end
        send_word(CMD_EOS, 8'($urandom_range(0, 255)));
        drain();
    endtask

    // Output held off while distinct bytes keep coming: input must stall
    task automatic test_backpressure();
        tx_quiet    = 1'b1;
        hold_cycles = 300;
        for (int i = 0; i < 20; i++)
            send_word(CMD_DATA, 8'(i * 37));
        send_word(CMD_EOS, 8'h00);
        drain();
        tx_quiet = 1'b0;
    endtask

    // Full rate on both sides
    task automatic test_full_rate();
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        for (int i = 0; i < 20; i++)
            send_word(CMD_DATA, 8'($urandom_range(0, 3)));
        send_word(CMD_EOS, 8'h00);
        drain();
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // Main sequence
    initial
    begin
        errors      = 0;
        tx_quiet    = 1'b0;
        rx_quiet    = 1'b0;
        hold_cycles = 0;
        run_len     = '0;
        run_byte    = '0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_DATA;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_run_lengths();
        test_random();
        test_backpressure();
        test_full_rate();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && code_q.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
